@@ hdl/tofp_pkg.sv @@
// ----------------------------------------------------------------------------
// tofp_pkg
// Shared types and constants for the TCP option fingerprint parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tofp_pkg;

  localparam logic [5:0] MAX_OPTION_BYTES = 6'd40;

  localparam logic [7:0] KIND_END   = 8'd0;
  localparam logic [7:0] KIND_NOP   = 8'd1;
  localparam logic [7:0] KIND_MSS   = 8'd2;
  localparam logic [7:0] KIND_SCALE = 8'd3;

  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] LEN_SCALE = 8'd3;
  localparam logic [7:0] LEN_MSS   = 8'd4;

  localparam logic [7:0] POS_DATA_HI = 8'd2;
  localparam logic [7:0] POS_DATA_LO = 8'd3;

  localparam logic [5:0] KIND_COUNT_MAX = 6'd63;

  localparam logic RECORD_KIND    = 1'b0;
  localparam logic RECORD_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // Results caused by one input byte: an optional kind record and an
  // optional end-of-area summary.
  typedef struct packed {
    logic        rec_valid;
    logic [7:0]  rec_kind;
    logic [5:0]  rec_count;
    logic        sum_valid;
    logic [15:0] sum_mss;
    logic [7:0]  sum_scale;
    logic [5:0]  sum_count;
    logic        sum_malformed;
  } step_result_t;

endpackage

`default_nettype wire

@@ hdl/tofp_in_if.sv @@
// ----------------------------------------------------------------------------
// tofp_in_if
// Valid/ready channel carrying one byte of the TCP options area.
// ----------------------------------------------------------------------------
`default_nettype none

interface tofp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] option_byte;
  logic [5:0] bytes_left;

  modport source (output valid, output option_byte, output bytes_left, input ready);
  modport sink   (input valid, input option_byte, input bytes_left, output ready);
endinterface

`default_nettype wire

@@ hdl/tofp_out_if.sv @@
// ----------------------------------------------------------------------------
// tofp_out_if
// Valid/ready channel carrying one parser result (kind record or summary).
// ----------------------------------------------------------------------------
`default_nettype none

interface tofp_out_if;
  logic        valid;
  logic        ready;
  logic        record_type;
  logic [7:0]  kind_code;
  logic [15:0] mss_word;
  logic [7:0]  window_scale;
  logic [5:0]  kind_count;
  logic        malformed;
  logic        last_of_run;

  modport source (output valid, output record_type, output kind_code,
                  output mss_word, output window_scale, output kind_count,
                  output malformed, output last_of_run, input ready);
  modport sink   (input valid, input record_type, input kind_code,
                  input mss_word, input window_scale, input kind_count,
                  input malformed, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/tofp_core.sv @@
// ----------------------------------------------------------------------------
// tofp_core
// Per-byte option parse state and the results each byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module tofp_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [7:0]            option_byte,
  input  wire logic [5:0]            bytes_left,
  output tofp_pkg::step_result_t     result
);
  import tofp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  cur_kind, cur_kind_next;
  logic [7:0]  cur_len, cur_len_next;
  logic [7:0]  position, position_next;
  logic [15:0] mss_store, mss_store_next;
  logic [7:0]  scale_store, scale_store_next;
  logic [5:0]  kinds_seen, kinds_seen_next;
  logic        bad_len, bad_len_next;

  logic [5:0]  rem;
  logic        last;
  logic [5:0]  count_inc;
  logic [7:0]  pos_inc;
  logic        accept;
  logic [7:0]  accept_kind;

  // step values before the end-of-area clear
  phase_t      phase_s;
  logic [7:0]  kind_s, len_s, pos_s, scale_s;
  logic [15:0] mss_s;
  logic [5:0]  kinds_s;
  logic        bad_s;

  assign rem       = (bytes_left > MAX_OPTION_BYTES) ? MAX_OPTION_BYTES : bytes_left;
  assign last      = (bytes_left == 6'd1);
  assign count_inc = (kinds_seen == KIND_COUNT_MAX) ? KIND_COUNT_MAX : kinds_seen + 6'd1;
  assign pos_inc   = position + 8'd1;

  always_comb begin
    phase_s     = phase;
    kind_s      = cur_kind;
    len_s       = cur_len;
    pos_s       = position;
    mss_s       = mss_store;
    scale_s     = scale_store;
    kinds_s     = kinds_seen;
    bad_s       = bad_len;
    accept      = 1'b0;
    accept_kind = cur_kind;
    unique case (phase)
      PH_KIND: begin
        kind_s      = option_byte;
        pos_s       = 8'd0;
        len_s       = 8'd0;
        accept_kind = option_byte;
        priority if (option_byte == KIND_END) begin
          accept  = 1'b1;
          phase_s = PH_DONE;
        end else if (option_byte == KIND_NOP) begin
          accept = 1'b1;
        end else if (rem < 6'd2) begin
          bad_s   = 1'b1;
          phase_s = PH_DONE;
        end else begin
          phase_s = PH_LEN;
        end
      end
      PH_LEN: begin
        if (option_byte < LEN_MIN || {1'b0, option_byte} > {3'd0, rem} + 9'd1) begin
          bad_s   = 1'b1;
          phase_s = PH_DONE;
        end else begin
          len_s   = option_byte;
          pos_s   = 8'd1;
          accept  = 1'b1;
          phase_s = (option_byte == LEN_MIN) ? PH_KIND : PH_DATA;
        end
      end
      PH_DATA: begin
        pos_s = pos_inc;
        if (cur_kind == KIND_MSS && cur_len >= LEN_MSS) begin
          if (pos_inc == POS_DATA_HI) begin
            mss_s = {option_byte, mss_store[7:0]};
          end else if (pos_inc == POS_DATA_LO) begin
            mss_s = {mss_store[15:8], option_byte};
          end
        end else if (cur_kind == KIND_SCALE && cur_len >= LEN_SCALE &&
                     pos_inc == POS_DATA_HI) begin
          scale_s = option_byte;
        end
        if ({1'b0, pos_inc} + 9'd1 >= {1'b0, cur_len}) begin
          phase_s = PH_KIND;
        end
      end
      PH_DONE: begin
        // hold until the area's last byte
      end
      default: begin
      end
    endcase
    if (accept) begin
      kinds_s = count_inc;
    end
  end

  // next state: the area's last byte clears everything
  always_comb begin
    if (last) begin
      phase_next       = PH_KIND;
      cur_kind_next    = 8'd0;
      cur_len_next     = 8'd0;
      position_next    = 8'd0;
      mss_store_next   = 16'd0;
      scale_store_next = 8'd0;
      kinds_seen_next  = 6'd0;
      bad_len_next     = 1'b0;
    end else begin
      phase_next       = phase_s;
      cur_kind_next    = kind_s;
      cur_len_next     = len_s;
      position_next    = pos_s;
      mss_store_next   = mss_s;
      scale_store_next = scale_s;
      kinds_seen_next  = kinds_s;
      bad_len_next     = bad_s;
    end
  end

  always_comb begin
    result.rec_valid     = accept;
    result.rec_kind      = accept_kind;
    result.rec_count     = kinds_s;
    result.sum_valid     = last;
    result.sum_mss       = mss_s;
    result.sum_scale     = scale_s;
    result.sum_count     = kinds_s;
    result.sum_malformed = bad_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KIND;
      cur_kind    <= 8'd0;
      cur_len     <= 8'd0;
      position    <= 8'd0;
      mss_store   <= 16'd0;
      scale_store <= 8'd0;
      kinds_seen  <= 6'd0;
      bad_len     <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      cur_kind    <= cur_kind_next;
      cur_len     <= cur_len_next;
      position    <= position_next;
      mss_store   <= mss_store_next;
      scale_store <= scale_store_next;
      kinds_seen  <= kinds_seen_next;
      bad_len     <= bad_len_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcp_option_fingerprint_parser.sv @@
// ----------------------------------------------------------------------------
// tcp_option_fingerprint_parser
// Walks a TCP options area one byte per transaction and reports each option
// kind it accepts, plus an end-of-area summary (MSS, window scale, count, malformed flag).
//
// opt_in carries one option byte and the count of bytes left in the area,
// this byte included; a count of 1 marks the last byte. res_out carries
// results: a kind record (END and NOP at their kind byte, other kinds at
// their length byte) and, on the last byte, a summary. last_of_run flags the
// final result of a byte.
// The results of a byte appear on res_out the cycle after it is
// accepted. Throughput: one byte per cycle while each byte yields at most one
// result and res_out does not stall; a byte with a record and a summary holds
// the output register, so the next byte waits while the record is delivered.
// The output register holds both results of one byte, and a new byte is taken
// in the same cycle its last pending result is delivered.
// Reset clears the parse state and drops any pending result. When res_out
// stalls, the pending results hold and opt_in deasserts ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_option_fingerprint_parser (
  input wire logic clk,
  input wire logic rst,
  tofp_in_if.sink   opt_in,
  tofp_out_if.source res_out
);
  import tofp_pkg::*;

  step_result_t step;
  step_result_t pend;
  logic         take;
  logic         pop;
  logic         rec_valid;
  logic         sum_valid;

  assign pop  = res_out.valid && res_out.ready;
  assign opt_in.ready = !(rec_valid || sum_valid) ||
                        (res_out.ready && (rec_valid ^ sum_valid));
  assign take = opt_in.valid && opt_in.ready;

  tofp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .option_byte (opt_in.option_byte),
    .bytes_left  (opt_in.bytes_left),
    .result      (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      sum_valid <= 1'b0;
    end else if (take) begin
      rec_valid <= step.rec_valid;
      sum_valid <= step.sum_valid;
    end else if (pop) begin
      // deliver the record first, then the summary
      if (rec_valid) begin
        rec_valid <= 1'b0;
      end else begin
        sum_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend <= step;
    end
  end

  assign res_out.valid = rec_valid || sum_valid;

  always_comb begin
    if (rec_valid) begin
      res_out.record_type  = RECORD_KIND;
      res_out.kind_code    = pend.rec_kind;
      res_out.mss_word     = 16'd0;
      res_out.window_scale = 8'd0;
      res_out.kind_count   = pend.rec_count;
      res_out.malformed    = 1'b0;
      res_out.last_of_run  = !sum_valid;
    end else begin
      res_out.record_type  = RECORD_SUMMARY;
      res_out.kind_code    = 8'd0;
      res_out.mss_word     = pend.sum_mss;
      res_out.window_scale = pend.sum_scale;
      res_out.kind_count   = pend.sum_count;
      res_out.malformed    = pend.sum_malformed;
      res_out.last_of_run  = 1'b1;
    end
  end

endmodule

`default_nettype wire
